>>> design/nspb_pkg.sv
package nspb_pkg;

  // Source frame store geometry
  localparam int SRC_MAX_W   = 256;
  localparam int SRC_MAX_H   = 256;
  localparam int SRC_COL_W   = $clog2(SRC_MAX_W);
  localparam int SRC_ROW_W   = $clog2(SRC_MAX_H);
  localparam int FRAME_DEPTH = SRC_MAX_W * SRC_MAX_H;
  localparam int FRAME_AW    = SRC_COL_W + SRC_ROW_W;

  // Palette geometry
  localparam int PAL_DEPTH = 32768;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);

  // Field widths
  localparam int PIX_W   = 15;
  localparam int COLOR_W = 32;
  localparam int POS_W   = 24;
  localparam int OCNT_W  = 11;
  localparam int OSIZE_W = 12;
  localparam int SSIZE_W = 9;
  localparam int FRAC_W  = 16;

  // Output size limit and rounding half in Q8.16
  localparam logic [OSIZE_W-1:0] OUT_MAX  = 12'd2048;
  localparam logic [POS_W:0]     HALF_Q16 = 25'h008000;

  // Result queue
  localparam int OUT_FIFO_DEPTH = 4;
  localparam int OUT_FIFO_AW    = $clog2(OUT_FIFO_DEPTH);
  localparam int OUT_FIFO_CW    = $clog2(OUT_FIFO_DEPTH + 3);

  // Command kinds carried in s_axis_tuser
  typedef enum logic [1:0] {
    CMD_PALETTE = 2'd0,
    CMD_PIXEL   = 2'd1,
    CMD_EMIT    = 2'd2
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_OUT_WIDTH  = 3'd0,
    REG_OUT_HEIGHT = 3'd1,
    REG_SRC_WIDTH  = 3'd2,
    REG_SRC_HEIGHT = 3'd3,
    REG_STEP_H     = 3'd4,
    REG_STEP_V     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [OSIZE_W-1:0] dst_width;
    logic [OSIZE_W-1:0] dst_height;
    logic [SSIZE_W-1:0] source_width;
    logic [SSIZE_W-1:0] source_height;
    logic [POS_W-1:0]   step_horizontal;
    logic [POS_W-1:0]   step_vertical;
  } cfg_t;

  // Scan result for the current output pixel
  typedef struct packed {
    logic [FRAME_AW-1:0] addr;
    logic                line_end;
    logic                frame_end;
  } scan_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               line_end;
    logic               frame_end;
  } out_beat_t;

endpackage

>>> design/nspb_raster.sv
module nspb_raster (
  input  logic          clk,
  input  logic          rst,
  input  nspb_pkg::cfg_t cfg,
  input  logic          advance,
  output nspb_pkg::scan_t scan
);
  import nspb_pkg::*;

  logic [POS_W-1:0]  column_position;
  logic [POS_W-1:0]  row_position;
  logic [OCNT_W-1:0] output_column;
  logic [OCNT_W-1:0] output_row;

  logic [OSIZE_W-1:0] width_last;
  logic [OSIZE_W-1:0] height_last;
  logic               line_end;
  logic               frame_end;
  logic [SRC_COL_W-1:0] src_col;
  logic [SRC_ROW_W-1:0] src_row;
  logic [POS_W:0]     col_next_sum;
  logic [POS_W:0]     row_next_sum;

  // Map output size onto last counter value, zero acting as one, sizes above OUT_MAX as OUT_MAX
  function automatic logic [OSIZE_W-1:0] out_last(input logic [OSIZE_W-1:0] v);
    logic [OSIZE_W-1:0] r;
    if (v == '0) r = '0;
    else if (v > OUT_MAX) r = OUT_MAX - OSIZE_W'(1);
    else r = v - OSIZE_W'(1);
    return r;
  endfunction

  // Round Q8.16 position and clamp to the last source index
  function automatic logic [SSIZE_W-1:0] pick(input logic [POS_W-1:0] pos,
                                              input logic [SSIZE_W-1:0] size,
                                              input logic [SSIZE_W-1:0] lim);
    logic [POS_W:0]     sum;
    logic [SSIZE_W-1:0] idx;
    logic [SSIZE_W-1:0] last;
    sum  = {1'b0, pos} + HALF_Q16;
    idx  = sum[POS_W:FRAC_W];
    last = (size == '0) ? '0 : size - SSIZE_W'(1);
    if (last > lim) last = lim;
    return (idx > last) ? last : idx;
  endfunction

  assign width_last  = out_last(cfg.dst_width);
  assign height_last = out_last(cfg.dst_height);
  assign line_end    = {1'b0, output_column} >= width_last;
  assign frame_end   = line_end && ({1'b0, output_row} >= height_last);

  assign src_col = SRC_COL_W'(pick(column_position, cfg.source_width,
                                   SSIZE_W'(SRC_MAX_W - 1)));
  assign src_row = SRC_ROW_W'(pick(row_position, cfg.source_height,
                                   SSIZE_W'(SRC_MAX_H - 1)));

  assign scan.addr      = {src_row, src_col};
  assign scan.line_end  = line_end;
  assign scan.frame_end = frame_end;

  assign col_next_sum = {1'b0, column_position} + {1'b0, cfg.step_horizontal};
  assign row_next_sum = {1'b0, row_position} + {1'b0, cfg.step_vertical};

  // Advance positions and counters, saturate positions, wrap after frame
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      output_column   <= '0;
      output_row      <= '0;
    end else if (advance) begin
      if (line_end) begin
        output_column   <= '0;
        column_position <= '0;
        if (frame_end) begin
          output_row   <= '0;
          row_position <= '0;
        end else begin
          output_row   <= output_row + OCNT_W'(1);
          row_position <= row_next_sum[POS_W] ? '1 : row_next_sum[POS_W-1:0];
        end
      end else begin
        output_column   <= output_column + OCNT_W'(1);
        column_position <= col_next_sum[POS_W] ? '1 : col_next_sum[POS_W-1:0];
      end
    end
  end

endmodule

>>> design/nearest_scaler_palette_blit.sv
// Nearest-neighbor frame scaler with a 15-bit to 32-bit palette lookup.
// Beats on s_axis carry a command in tuser: palette write, source pixel
// write, or emit of the next output pixel in raster order. The block takes
// one beat per clock while s_axis_tready is high; an emit result passes
// the frame store read, the palette read and the result queue on its way
// to m_axis, with each memory read registered. A four-entry queue lets input
// beats keep flowing while results wait; s_axis_tready drops only when four
// results are either queued or in flight, and stays low during reset.
// Writes and reads of both memories follow beat order, so no interlock is
// needed. Neither memory is cleared: an entry must be written before an
// emit reads it. Configuration writes are taken on every cycle outside
// reset and must only happen while the block is idle.
module nearest_scaler_palette_blit (
  input  logic        clk,
  input  logic        rst,
  // Input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: palette_index[14:0], palette_color[46:15], pixel_column[54:47],
  //        pixel_row[62:55], pixel_value[77:63], zero fill [79:78]
  input  logic [79:0] s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_color[31:0]
  output logic [31:0] m_axis_tdata,
  // tlast: line_end
  output logic        m_axis_tlast,
  // tuser: frame_end[0]
  output logic        m_axis_tuser,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import nspb_pkg::*;

  cfg_t cfg;
  scan_t scan;

  logic [PAL_AW-1:0]    palette_index;
  logic [COLOR_W-1:0]   palette_color;
  logic [SRC_COL_W-1:0] pixel_column;
  logic [SRC_ROW_W-1:0] pixel_row;
  logic [PIX_W-1:0]     pixel_value;
  cmd_t                 cmd;
  logic                 in_fire;
  logic                 emit;

  logic [PIX_W-1:0]   frame_mem [FRAME_DEPTH];
  logic [COLOR_W-1:0] palette_mem [PAL_DEPTH];

  logic               s1_valid, s1_line_end, s1_frame_end;
  logic [PIX_W-1:0]   frame_q;
  logic               s2_valid, s2_line_end, s2_frame_end;
  logic [COLOR_W-1:0] palette_q;

  out_beat_t              fifo_mem [OUT_FIFO_DEPTH];
  logic [OUT_FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [OUT_FIFO_CW-1:0] fifo_count;
  logic [OUT_FIFO_CW-1:0] pending;
  logic                   push, pop;
  out_beat_t              head;

  // Unpack input beat
  assign palette_index = s_axis_tdata[14:0];
  assign palette_color = s_axis_tdata[46:15];
  assign pixel_column  = s_axis_tdata[54:47];
  assign pixel_row     = s_axis_tdata[62:55];
  assign pixel_value   = s_axis_tdata[77:63];
  assign cmd           = cmd_t'(s_axis_tuser);

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign emit    = in_fire && (cmd == CMD_EMIT);

  // Configuration registers
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dst_width       <= OSIZE_W'(256);
      cfg.dst_height      <= OSIZE_W'(224);
      cfg.source_width    <= SSIZE_W'(256);
      cfg.source_height   <= SSIZE_W'(224);
      cfg.step_horizontal <= POS_W'(65536);
      cfg.step_vertical   <= POS_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_OUT_WIDTH:  cfg.dst_width       <= cfg_data[OSIZE_W-1:0];
        REG_OUT_HEIGHT: cfg.dst_height      <= cfg_data[OSIZE_W-1:0];
        REG_SRC_WIDTH:  cfg.source_width    <= cfg_data[SSIZE_W-1:0];
        REG_SRC_HEIGHT: cfg.source_height   <= cfg_data[SSIZE_W-1:0];
        REG_STEP_H:     cfg.step_horizontal <= cfg_data[POS_W-1:0];
        REG_STEP_V:     cfg.step_vertical   <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Scan position and source address generation
  nspb_raster u_raster (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (emit),
    .scan    (scan)
  );

  // Frame store: write source pixels, read the scanned pixel
  always_ff @(posedge clk) begin
    if (in_fire && (cmd == CMD_PIXEL)) begin
      frame_mem[{pixel_row, pixel_column}] <= pixel_value;
    end
    if (emit) begin
      frame_q <= frame_mem[scan.addr];
    end
  end

  always_ff @(posedge clk) begin
    s1_line_end  <= scan.line_end;
    s1_frame_end <= scan.frame_end;
    s2_line_end  <= s1_line_end;
    s2_frame_end <= s1_frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= emit;
      s2_valid <= s1_valid;
    end
  end

  // Palette: write entries, look up the fetched pixel (read before later writes)
  always_ff @(posedge clk) begin
    if (in_fire && (cmd == CMD_PALETTE)) begin
      palette_mem[palette_index] <= palette_color;
    end
    if (s1_valid) begin
      palette_q <= palette_mem[frame_q];
    end
  end

  // Result queue
  assign push = s2_valid;
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign head = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{color: palette_q, line_end: s2_line_end,
                            frame_end: s2_frame_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + OUT_FIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + OUT_FIFO_AW'(1);
      fifo_count <= fifo_count + OUT_FIFO_CW'(push) - OUT_FIFO_CW'(pop);
    end
  end

  // Hold input while every queue slot is claimed
  assign pending       = fifo_count + OUT_FIFO_CW'(s1_valid) + OUT_FIFO_CW'(s2_valid);
  assign s_axis_tready = !rst && (pending < OUT_FIFO_CW'(OUT_FIFO_DEPTH));

  assign m_axis_tvalid = fifo_count != '0;
  assign m_axis_tdata  = head.color;
  assign m_axis_tlast  = head.line_end;
  assign m_axis_tuser  = head.frame_end;

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count < OUT_FIFO_CW'(OUT_FIFO_DEPTH)) || pop)
    else $error("result queue overflow");

  a_emit_reaches_s1: assert property (@(posedge clk) disable iff (rst)
    emit |=> s1_valid)
    else $error("emit beat lost before frame read");

  a_s1_reaches_s2: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> s2_valid)
    else $error("emit beat lost before palette read");

  a_frame_implies_line: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("frame end without line end");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= OUT_FIFO_CW'(OUT_FIFO_DEPTH))
    else $error("more results in flight than queue slots");

endmodule
